### hw/rtl/pfr_pkg.sv
// pfr_pkg: shared types and constants for the packet frame receiver
// holds the controller/datapath command and status structs and byte codes
// no dependencies
package pfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned PLEN_W     = 7;
    localparam int unsigned IDX_W      = 7;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE = 1'd1;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd204;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'd185;
    localparam logic [BYTE_W-1:0] ID_LED_SET = 8'h81;
    localparam logic [BYTE_W-1:0] ID_LED_GET = 8'h83;
    localparam logic [BYTE_W-1:0] END_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] END_LF     = 8'h0A;

    typedef enum logic [1:0] {
        MODE_ORDINARY = 2'd0,
        MODE_SET      = 2'd1,
        MODE_GET      = 2'd2
    } led_mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE       = 2'd0,
        KIND_LED_SET    = 2'd1,
        KIND_LED_STATUS = 2'd2
    } kind_t;

    // commands from the controller, at most one active per cycle
    typedef struct packed {
        logic take_length;
        logic take_payload;
        logic take_led;
        logic emit_led;
        logic rd_issue;
        logic load_byte;
    } pfr_cmd_t;

    // datapath status toward the controller
    typedef struct packed {
        logic      head_match;
        logic      len_bad;
        logic      no_room;
        logic      idx_zero;
        logic      id_set;
        logic      idx_last;
        logic      tail_match;
        logic      cksum_match;
        logic      is_cr;
        logic      is_lf;
        led_mode_t mode;
        logic      rd_last;
        logic      out_free;
    } pfr_status_t;

endpackage

### hw/rtl/packet_frame_receiver_core.sv
// packet_frame_receiver_core: top level of the serial frame receiver
// depends on pfr_pkg, pfr_ctrl, pfr_dpath (which holds pfr_ram)
//
// Takes received bytes one beat at a time and parses frames of the form
// head, length, id + payload, tail, checksum, CR, LF, where the length counts
// the id plus payload and the checksum is the 8-bit bsd rotate-and-add sum over
// id and payload. While a frame is being parsed a byte is taken every cycle.
// A valid ordinary frame is delivered from the payload store as one beat per
// buffered byte, id first, each carrying length-1 and a last mark on the final
// beat; each beat passes a read state and then a load state for the store's
// registered read port, and no byte is taken during the burst. Each led frame
// gives a single result beat: an led-set frame (id 0x81) commits and reports
// its led byte, an led-get frame (id 0x83) reports the current led value.
// Frames with a length of zero or above PAYLOAD_DEPTH, frames that meet a byte
// with too little queue space, and frames failing the tail, checksum, CR or LF
// check are dropped silently. The output register lets a finished result wait
// while the next frame is received. The payload store has no reset; only
// entries written by the current frame are ever read.
module packet_frame_receiver_core #(
    parameter int unsigned PAYLOAD_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration writes
    input  logic                          cfg_write,
    input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfr_pkg::BYTE_W-1:0]    cfg_data,

    // received byte channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pfr_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [pfr_pkg::BYTE_W-1:0]    rx_space,

    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pfr_pkg::KIND_W-1:0]    kind,
    output logic [pfr_pkg::BYTE_W-1:0]    data,
    output logic [pfr_pkg::PLEN_W-1:0]    payload_length,
    output logic                          last
);

    // command and status between the controller and the datapath
    pfr_pkg::pfr_cmd_t    cmd;
    pfr_pkg::pfr_status_t sts;

    // controller: frame phase tracking, delivery sequencing, input stall
    pfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: head/tail registers, checksum, counters, led state,
    // payload store and the output register
    pfr_dpath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .rx_space       (rx_space),
        .cmd            (cmd),
        .sts            (sts),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .kind           (kind),
        .data           (data),
        .payload_length (payload_length),
        .last           (last)
    );

endmodule

### hw/rtl/pfr_ram.sv
// pfr_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module pfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pfr_ctrl.sv
// pfr_ctrl: frame parsing and delivery state machine
// depends on pfr_pkg for command and status structs
module pfr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pfr_pkg::pfr_status_t sts,
    output pfr_pkg::pfr_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_HEAD    = 11'b000_0000_0001,
        ST_LENGTH  = 11'b000_0000_0010,
        ST_PAYLOAD = 11'b000_0000_0100,
        ST_LEDS    = 11'b000_0000_1000,
        ST_TAIL    = 11'b000_0001_0000,
        ST_CKSUM   = 11'b000_0010_0000,
        ST_END1    = 11'b000_0100_0000,
        ST_END2    = 11'b000_1000_0000,
        ST_EMIT    = 11'b001_0000_0000,
        ST_READ    = 11'b010_0000_0000,
        ST_LOAD    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   parsing;
    logic   in_fire;

    // bytes are taken only while a frame is being parsed
    assign parsing = (state_reg == ST_HEAD) || (state_reg == ST_LENGTH) ||
                     (state_reg == ST_PAYLOAD) || (state_reg == ST_LEDS) ||
                     (state_reg == ST_TAIL) || (state_reg == ST_CKSUM) ||
                     (state_reg == ST_END1) || (state_reg == ST_END2);
    assign in_stall = !parsing;
    assign in_fire  = in_valid && parsing;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HEAD:
            begin
                if (in_fire && sts.head_match)
                begin
                    state_next = ST_LENGTH;
                end
            end
            ST_LENGTH:
            begin
                if (in_fire)
                begin
                    cmd.take_length = 1'b1;
                    state_next = sts.len_bad ? ST_HEAD : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (in_fire)
                begin
                    if (sts.no_room)
                    begin
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        cmd.take_payload = 1'b1;
                        if (sts.idx_zero && sts.id_set)
                        begin
                            state_next = ST_LEDS;
                        end
                        else if (sts.idx_last)
                        begin
                            state_next = ST_TAIL;
                        end
                    end
                end
            end
            ST_LEDS:
            begin
                if (in_fire)
                begin
                    cmd.take_led = 1'b1;
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (in_fire)
                begin
                    state_next = sts.tail_match ? ST_CKSUM : ST_HEAD;
                end
            end
            ST_CKSUM:
            begin
                if (in_fire)
                begin
                    state_next = sts.cksum_match ? ST_END1 : ST_HEAD;
                end
            end
            ST_END1:
            begin
                if (in_fire)
                begin
                    state_next = sts.is_cr ? ST_END2 : ST_HEAD;
                end
            end
            ST_END2:
            begin
                if (in_fire)
                begin
                    if (!sts.is_lf)
                    begin
                        state_next = ST_HEAD;
                    end
                    else if (sts.mode == pfr_pkg::MODE_ORDINARY)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_led = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    state_next = sts.rd_last ? ST_HEAD : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_HEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // the final delivered byte ends the burst
    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_byte && sts.rd_last) |=> (state_reg == ST_HEAD))
        else $error("delivery burst did not end after the last byte");

    // a byte with no room drops the frame and nothing is stored
    a_no_room_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAYLOAD && in_fire && sts.no_room)
            |-> (!cmd.take_payload && state_next == ST_HEAD))
        else $error("frame not dropped on missing queue room");

endmodule

### hw/rtl/pfr_dpath.sv
// pfr_dpath: frame registers, bsd checksum, payload store and output register
// depends on pfr_pkg and pfr_ram
module pfr_dpath #(
    parameter int unsigned PAYLOAD_DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pfr_pkg::BYTE_W-1:0]           cfg_data,
    input  logic [pfr_pkg::BYTE_W-1:0]           rx_byte,
    input  logic [pfr_pkg::BYTE_W-1:0]           rx_space,
    input  pfr_pkg::pfr_cmd_t                    cmd,
    output pfr_pkg::pfr_status_t                 sts,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [pfr_pkg::KIND_W-1:0]           kind,
    output logic [pfr_pkg::BYTE_W-1:0]           data,
    output logic [pfr_pkg::PLEN_W-1:0]           payload_length,
    output logic                                 last
);

    localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);
    localparam logic [pfr_pkg::BYTE_W-1:0] DEPTH_B = pfr_pkg::BYTE_W'(PAYLOAD_DEPTH);

    logic [pfr_pkg::BYTE_W-1:0] head_reg, head_next;
    logic [pfr_pkg::BYTE_W-1:0] tail_reg, tail_next;
    logic [pfr_pkg::BYTE_W-1:0] flen_reg, flen_next;
    logic [pfr_pkg::BYTE_W-1:0] cks_reg, cks_next;
    logic [pfr_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [pfr_pkg::IDX_W-1:0]  rd_cnt_reg, rd_cnt_next;
    pfr_pkg::led_mode_t         mode_reg, mode_next;
    logic [pfr_pkg::BYTE_W-1:0] led_reg, led_next;
    logic [pfr_pkg::BYTE_W-1:0] pend_reg, pend_next;

    logic                       ov_reg, ov_next;
    pfr_pkg::kind_t             kind_reg, kind_next;
    logic [pfr_pkg::BYTE_W-1:0] data_reg, data_next;
    logic [pfr_pkg::PLEN_W-1:0] plen_reg, plen_next;
    logic                       last_reg, last_next;

    logic [pfr_pkg::BYTE_W-1:0] cks_add;
    logic                       ram_we;
    logic                       ram_re;
    logic [pfr_pkg::BYTE_W-1:0] ram_q;
    logic                       out_free;
    logic                       rd_last;

    // rotate right by one, then add
    assign cks_add = {cks_reg[0], cks_reg[pfr_pkg::BYTE_W-1:1]} + rx_byte;

    assign out_free = !ov_reg || !out_stall;
    assign rd_last  = (pfr_pkg::BYTE_W'(rd_cnt_reg) + 8'd1) == flen_reg;

    // the id byte of an led frame is not stored
    assign ram_we = cmd.take_payload &&
                    !((idx_reg == '0) && ((rx_byte == pfr_pkg::ID_LED_SET) ||
                                          (rx_byte == pfr_pkg::ID_LED_GET)));
    assign ram_re = cmd.rd_issue;

    pfr_ram #(
        .WIDTH (pfr_pkg::BYTE_W),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_q)
    );

    always_comb
    begin
        sts.head_match  = rx_byte == head_reg;
        sts.len_bad     = (rx_byte == '0) || (rx_byte > DEPTH_B);
        sts.no_room     = rx_space <= flen_reg;
        sts.idx_zero    = idx_reg == '0;
        sts.id_set      = rx_byte == pfr_pkg::ID_LED_SET;
        sts.idx_last    = (pfr_pkg::BYTE_W'(idx_reg) + 8'd1) >= flen_reg;
        sts.tail_match  = rx_byte == tail_reg;
        sts.cksum_match = rx_byte == cks_reg;
        sts.is_cr       = rx_byte == pfr_pkg::END_CR;
        sts.is_lf       = rx_byte == pfr_pkg::END_LF;
        sts.mode        = mode_reg;
        sts.rd_last     = rd_last;
        sts.out_free    = out_free;
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        flen_next   = flen_reg;
        cks_next    = cks_reg;
        idx_next    = idx_reg;
        rd_cnt_next = rd_cnt_reg;
        mode_next   = mode_reg;
        led_next    = led_reg;
        pend_next   = pend_reg;
        ov_next     = ov_reg && out_stall;
        kind_next   = kind_reg;
        data_next   = data_reg;
        plen_next   = plen_reg;
        last_next   = last_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                pfr_pkg::CFG_HEAD_BYTE: head_next = cfg_data;
                pfr_pkg::CFG_TAIL_BYTE: tail_next = cfg_data;
                default:                head_next = head_reg;
            endcase
        end

        if (cmd.take_length)
        begin
            flen_next   = rx_byte;
            cks_next    = '0;
            idx_next    = '0;
            rd_cnt_next = '0;
            mode_next   = pfr_pkg::MODE_ORDINARY;
        end

        if (cmd.take_payload)
        begin
            cks_next = cks_add;
            idx_next = idx_reg + 7'd1;
            if ((idx_reg == '0) && (rx_byte == pfr_pkg::ID_LED_GET))
            begin
                mode_next = pfr_pkg::MODE_GET;
            end
        end

        if (cmd.take_led)
        begin
            pend_next = rx_byte;
            cks_next  = cks_add;
            mode_next = pfr_pkg::MODE_SET;
        end

        if (cmd.emit_led)
        begin
            ov_next   = 1'b1;
            plen_next = '0;
            last_next = 1'b1;
            if (mode_reg == pfr_pkg::MODE_SET)
            begin
                led_next  = pend_reg;
                kind_next = pfr_pkg::KIND_LED_SET;
                data_next = pend_reg;
            end
            else
            begin
                kind_next = pfr_pkg::KIND_LED_STATUS;
                data_next = led_reg;
            end
        end

        if (cmd.load_byte)
        begin
            ov_next     = 1'b1;
            kind_next   = pfr_pkg::KIND_BYTE;
            data_next   = ram_q;
            plen_next   = pfr_pkg::PLEN_W'(flen_reg - 8'd1);
            last_next   = rd_last;
            rd_cnt_next = rd_cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= pfr_pkg::HEAD_RESET;
            tail_reg   <= pfr_pkg::TAIL_RESET;
            flen_reg   <= '0;
            cks_reg    <= '0;
            idx_reg    <= '0;
            rd_cnt_reg <= '0;
            mode_reg   <= pfr_pkg::MODE_ORDINARY;
            led_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            flen_reg   <= flen_next;
            cks_reg    <= cks_next;
            idx_reg    <= idx_next;
            rd_cnt_reg <= rd_cnt_next;
            mode_reg   <= mode_next;
            led_reg    <= led_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        kind_reg <= kind_next;
        data_reg <= data_next;
        plen_reg <= plen_next;
        last_reg <= last_next;
    end

    assign out_valid      = ov_reg;
    assign kind           = kind_reg;
    assign data           = data_reg;
    assign payload_length = plen_reg;
    assign last           = last_reg;

    // store is written only while receiving and read only while delivering
    a_ram_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("payload store written and read in one cycle");

    // delivery never reads past the frame length
    a_rd_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_byte |-> (pfr_pkg::BYTE_W'(rd_cnt_reg) < flen_reg))
        else $error("delivery read beyond the frame");

endmodule
